// ===== hdl/lodt_pkg.sv =====
// Shared types, constants and widths for the long-delay overflow timer.
package lodt_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 16;
  localparam int unsigned TICK_W           = 16;
  localparam int unsigned PERIOD_W         = 17;
  localparam int unsigned CFG_DATA_W       = 17;
  localparam int unsigned DELAY_W          = 23;
  localparam int unsigned COUNT_OUT_W      = 16;
  localparam int unsigned TARGET_W         = 32;
  localparam int unsigned NUM_W            = 33;
  localparam int unsigned DEN_W            = 17;
  localparam int unsigned DIV_CNT_W        = 6;
  localparam int unsigned MS_TO_US         = 1000;

  localparam logic [TICK_W-1:0]   TICK_TIME_RST = 16'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 17'd256;

  typedef enum logic [1:0] {
    OP_SET_DELAY = 2'd0,
    OP_START     = 2'd1,
    OP_STOP      = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_TICK_TIME = 1'b0,
    CFG_PERIOD    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV1,
    ST_DIV2
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [DELAY_W-1:0] wait_ms;
  } in_item_t;

  typedef struct packed {
    logic                   expired;
    logic [COUNT_OUT_W-1:0] counter_now;
    logic [TARGET_W-1:0]    target_now;
    logic                   is_running;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
    logic [DEN_W-1:0] remainder;
  } div_res_t;

endpackage

// ===== hdl/long_delay_overflow_timer_unit.sv =====
// Long-delay timer: counter, overflow count and set-delay sequencer.
//
// Items arrive on a valid/ready input channel and each gives exactly one result
// item on a valid/ready output channel. For start, stop and tick items the
// result is registered at the accepting edge and shown in the next cycle, so
// ticks can follow back to back while the receiver keeps ready high.
// For a set-delay item the millisecond count is scaled by
// 1000 and then passed twice through one shared 33-step restoring divider,
// first by the tick length and then by the counter period. Input ready is low
// for the whole sequence. The remainder of the second division gives the preload
// value, and the quotient, rounded up, the overflow target.
// Ready also stays low while a result waits in the output register and the
// receiver stalls; nothing is dropped. Configuration writes (tick length,
// period) are taken at any edge with the write enable high and should only be
// made while no item is in progress.
// Reset clears the counter, overflow count, target and preload, stops the
// timer, and restores a tick length of 64 us and a period of 256 ticks.
module long_delay_overflow_timer_unit
  import lodt_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CB = COUNTER_BITS;
  localparam logic [CB:0] PER_MAX = (CB+1)'(1) << CB;

  state_e                state_q, state_d;
  logic [TICK_W-1:0]     tick_time_q, tick_time_d;
  logic [PERIOD_W-1:0]   period_q, period_d;
  logic [CB-1:0]         cnt_q, cnt_d;
  logic [TARGET_W-1:0]   ovf_q, ovf_d;
  logic [TARGET_W-1:0]   target_q, target_d;
  logic [CB-1:0]         reload_q, reload_d;
  logic                  running_q, running_d;
  logic [DELAY_W-1:0]    ms_q, ms_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic                  load_out;

  logic [TICK_W-1:0]     tt_eff;
  logic [CB:0]           per_eff;
  logic [CB:0]           cnt_inc;
  logic [TARGET_W-1:0]   ovf_inc;
  logic [TARGET_W+1:0]   tgt_sum;
  logic                  expired;
  logic                  in_acc;

  div_req_t              div_req;
  div_res_t              div_res;

  lodt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_comb begin
    tt_eff = (tick_time_q == '0) ? TICK_W'(1) : tick_time_q;
    if (period_q == '0) begin
      per_eff = (CB+1)'(1);
    end else if (period_q > PERIOD_W'(PER_MAX)) begin
      per_eff = PER_MAX;
    end else begin
      per_eff = period_q[CB:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cnt_inc    = {1'b0, cnt_q} + (CB+1)'(1);
  assign ovf_inc    = ovf_q + TARGET_W'(1);
  assign tgt_sum    = (TARGET_W+2)'(div_res.quotient)
                    + (TARGET_W+2)'(div_res.remainder != '0);

  always_comb begin
    state_d          = state_q;
    tick_time_d      = tick_time_q;
    period_d         = period_q;
    cnt_d            = cnt_q;
    ovf_d            = ovf_q;
    target_d         = target_q;
    reload_d         = reload_q;
    running_d        = running_q;
    ms_d             = ms_q;
    out_valid_d      = out_valid_q;
    load_out         = 1'b0;
    expired          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = NUM_W'(ms_q) * NUM_W'(MS_TO_US);
    div_req.divisor  = DEN_W'(tt_eff);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_TIME: tick_time_d = cfg_data_i[TICK_W-1:0];
        CFG_PERIOD:    period_d    = cfg_data_i[PERIOD_W-1:0];
        default:       ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.operation)
            OP_SET_DELAY: begin
              ms_d    = in_data_i.wait_ms;
              state_d = ST_LOAD;
            end
            OP_START: begin
              running_d = 1'b1;
              load_out  = 1'b1;
            end
            OP_STOP: begin
              running_d = 1'b0;
              load_out  = 1'b1;
            end
            OP_TICK: begin
              load_out = 1'b1;
              if (running_q) begin
                if (cnt_inc >= per_eff) begin
                  cnt_d = '0;
                  ovf_d = ovf_inc;
                  if (target_q != '0 && ovf_inc == target_q) begin
                    ovf_d   = '0;
                    cnt_d   = reload_q;
                    expired = 1'b1;
                  end
                end else begin
                  cnt_d = cnt_inc[CB-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_res.done) begin
          // Tick count is ready: divide it by the counter period next.
          div_req.start    = 1'b1;
          div_req.dividend = div_res.quotient;
          div_req.divisor  = DEN_W'(per_eff);
          state_d          = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_res.done) begin
          if (tgt_sum > (TARGET_W+2)'({TARGET_W{1'b1}})) begin
            target_d = '1;
          end else begin
            target_d = tgt_sum[TARGET_W-1:0];
          end
          if (div_res.remainder == '0) begin
            reload_d = '0;
          end else begin
            reload_d = CB'(per_eff - div_res.remainder[CB:0]);
          end
          cnt_d    = reload_d;
          ovf_d    = '0;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end
    out_d.expired     = expired;
    out_d.counter_now = COUNT_OUT_W'(cnt_d);
    out_d.target_now  = target_d;
    out_d.is_running  = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_time_q <= TICK_TIME_RST;
      period_q    <= PERIOD_RST;
      cnt_q       <= '0;
      ovf_q       <= '0;
      target_q    <= '0;
      reload_q    <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_time_q <= tick_time_d;
      period_q    <= period_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      target_q    <= target_d;
      reload_q    <= reload_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ms_q <= ms_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A set-delay item is only taken once the output slot is free, so its result
  // can always be written when the second division completes.
  a_slot_free_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !out_valid_q)
    else $error("output slot occupied during set-delay sequence");

  a_count_below_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_q != '0 |-> ovf_q < target_q)
    else $error("overflow count reached target without expiry");

  a_expiry_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.expired |-> out_data_o.counter_now == COUNT_OUT_W'(reload_q))
    else $error("expiry item does not show the preload value");

  a_div_only_in_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV1 || state_q == ST_DIV2)
    else $error("divider finished outside the set-delay sequence");

endmodule

// ===== hdl/lodt_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module lodt_div
  import lodt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     quot_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;

  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       diff;
  logic                 fits;
  logic [DEN_W-1:0]     rem_d;

  // The dividend register shifts out its top bit while quotient bits shift in.
  always_comb begin
    rem_sh = {rem_q, quot_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = ~diff[DEN_W];
    rem_d  = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      den_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], fits};
      rem_q  <= rem_d;
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quot_q;
  assign res_o.remainder = rem_q;

  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished division");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && den_q != '0 |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

endmodule

// ===== tb/sv/lodt_result_checker.sv =====
// Checker for the long-delay timer: watches both channels, predicts each result item and compares.
module lodt_result_checker
  import lodt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted copy of the configuration and the timer state.
  logic [TICK_W-1:0]      tick_len_us;
  logic [PERIOD_W-1:0]    period_reg;
  logic [COUNT_OUT_W-1:0] count_q;
  logic [TARGET_W-1:0]    wraps_q;
  logic [TARGET_W-1:0]    target_q;
  logic [COUNT_OUT_W-1:0] preload_q;
  logic                   run_q;

  out_item_t timer_results_q[$];
  out_item_t got_item;
  out_item_t want_item;

  task automatic advance_timer(input in_item_t item);
    longint unsigned per;
    longint unsigned tt;
    longint unsigned ticks;
    longint unsigned tgt;
    longint unsigned rem;
    logic            hit;
    out_item_t       res;
    hit = 1'b0;
    // A period of zero counts as one; anything above the counter range saturates.
    per = longint'(period_reg);
    if (per == 0) per = 1;
    if (per > (64'd1 << COUNTER_BITS_DEF)) per = 64'd1 << COUNTER_BITS_DEF;
    case (item.operation)
      OP_SET_DELAY: begin
        tt = (tick_len_us == '0) ? 64'd1 : longint'(tick_len_us);
        ticks = (longint'(item.wait_ms) * MS_TO_US) / tt;
        tgt = ticks / per;
        rem = ticks % per;
        if (rem != 0) tgt = tgt + 1;
        if (tgt > 64'hFFFF_FFFF) tgt = 64'hFFFF_FFFF;
        target_q = 32'(tgt);
        preload_q = 16'((per - rem) % per);
        count_q = preload_q;
        wraps_q = '0;
      end
      OP_START: run_q = 1'b1;
      OP_STOP:  run_q = 1'b0;
      OP_TICK: begin
        if (run_q) begin
          if (longint'(count_q) + 1 >= per) begin
            count_q = '0;
            wraps_q = wraps_q + 1'b1;
            if (target_q != '0 && wraps_q == target_q) begin
              wraps_q = '0;
              count_q = preload_q;
              hit = 1'b1;
            end
          end else begin
            count_q = count_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.expired     = hit;
    res.counter_now = count_q;
    res.target_now  = target_q;
    res.is_running  = run_q;
    timer_results_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_len_us  = TICK_TIME_RST;
      period_reg   = PERIOD_RST;
      count_q      = '0;
      wraps_q      = '0;
      target_q     = '0;
      preload_q    = '0;
      run_q        = 1'b0;
      timer_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TICK_TIME: tick_len_us = cfg_data_i[TICK_W-1:0];
          CFG_PERIOD:    period_reg  = cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got_item = out_data_i;
        if (timer_results_q.size() == 0) begin
          $error("result item with no prediction waiting: %p", got_item);
          fail_count_o = fail_count_o + 1;
        end else begin
          want_item = timer_results_q.pop_front();
          if (got_item.expired !== want_item.expired) begin
            $error("expired: expected %0d, got %0d", want_item.expired, got_item.expired);
            fail_count_o = fail_count_o + 1;
          end
          if (got_item.counter_now !== want_item.counter_now) begin
            $error("counter_now: expected %0d, got %0d",
                   want_item.counter_now, got_item.counter_now);
            fail_count_o = fail_count_o + 1;
          end
          if (got_item.target_now !== want_item.target_now) begin
            $error("target_now: expected %0d, got %0d",
                   want_item.target_now, got_item.target_now);
            fail_count_o = fail_count_o + 1;
          end
          if (got_item.is_running !== want_item.is_running) begin
            $error("is_running: expected %0d, got %0d",
                   want_item.is_running, got_item.is_running);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) advance_timer(in_data_i);
      pending_o = timer_results_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the long-delay timer testbench: clock, reset, stimulus and verdict.
module tb
  import lodt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 267;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  cfg_reg_e              cfg_idx   = CFG_TICK_TIME;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles        = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  long_delay_overflow_timer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  lodt_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Entered and left at a falling edge; valid stays high when the next item follows at once.
  task automatic send_item(input op_e op, input logic [DELAY_W-1:0] ms);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, wait_ms: ms};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end
    items_sent = items_sent + 1;
  endtask

  task automatic drain_timer();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] tick_us,
                            input logic [PERIOD_W-1:0] period);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TICK_TIME;
    cfg_data <= CFG_DATA_W'(tick_us);
    @(negedge clk);
    cfg_idx  <= CFG_PERIOD;
    cfg_data <= CFG_DATA_W'(period);
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned tick_us;
    int unsigned period;
    int unsigned ms_max;
    int unsigned phase_start;
    int unsigned burst;
    bit          paused;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset timing of 64 us and 256 ticks per wrap.
    send_item(OP_TICK, '0);
    send_item(OP_STOP, '1);
    send_item(OP_SET_DELAY, '0);
    send_item(OP_START, '0);
    send_item(OP_START, '1);
    repeat (2) send_item(OP_TICK, '0);
    // One millisecond is 15 ticks: one wrap, preloaded to 241, while running.
    send_item(OP_SET_DELAY, 23'd1);
    repeat (16) send_item(OP_TICK, '1);
    send_item(OP_STOP, '0);
    send_item(OP_TICK, '0);
    drain_timer();

    // Zero tick length and zero period both count as one; the target saturates.
    set_timing('0, '0);
    send_item(OP_SET_DELAY, '1);
    send_item(OP_START, '0);
    repeat (3) send_item(OP_TICK, '0);
    drain_timer();

    // Full counter range leaves the counter high, then a short period makes it wrap early.
    set_timing(16'd1, 17'd65536);
    send_item(OP_SET_DELAY, 23'd1);
    repeat (3) send_item(OP_TICK, '0);
    drain_timer();
    set_timing(16'hFFFF, 17'd4);
    send_item(OP_TICK, '0);
    send_item(OP_SET_DELAY, '1);
    drain_timer();
    set_timing(16'hFFFF, 17'h1FFFF);
    send_item(OP_SET_DELAY, 23'd1);
    send_item(OP_TICK, '0);
    drain_timer();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin tick_us = 1000;  period = 4;      ms_max = 40;   end
        1:       begin tick_us = 500;   period = 1;      ms_max = 15;   end
        2:       begin tick_us = 65535; period = 7;      ms_max = 3000; end
        3:       begin tick_us = 64;    period = 256;    ms_max = 2;    end
        4:       begin tick_us = 0;     period = 0;      ms_max = 0;    end
        default: begin tick_us = 65535; period = 131071; ms_max = 2000; end
      endcase
      if (phase < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 80;
      end else if (phase < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_timing(TICK_W'(tick_us), PERIOD_W'(period));
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (!paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
          drain_timer();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          // A short delay, then a start and a burst of 1 to 40 ticks with rare stops.
          send_item(OP_SET_DELAY, DELAY_W'($urandom_range(ms_max)));
          send_item(OP_START, DELAY_W'($urandom));
          burst = $urandom_range(40, 1);
          repeat (burst) begin
            if ($urandom_range(99) < 3) send_item(OP_STOP, DELAY_W'($urandom));
            else send_item(OP_TICK, DELAY_W'($urandom));
          end
        end else begin
          send_item(op_e'($urandom_range(3)), DELAY_W'($urandom));
        end
      end
      drain_timer();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lodt_pkg.sv
hdl/lodt_div.sv
hdl/long_delay_overflow_timer_unit.sv
tb/sv/lodt_result_checker.sv
tb/sv/tb.sv
